>>> rtl/slot_allocator_delayed_reuse_core_defines.svh
// Assertion macros shared by the slot allocator checker.
`ifndef SLOT_ALLOCATOR_DELAYED_REUSE_CORE_DEFINES_SVH
`define SLOT_ALLOCATOR_DELAYED_REUSE_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define SADR_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define SADR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/sadr_pkg.sv
// Package: types, codes and defaults of the slot allocator.
`timescale 1ns / 1ps

package sadr_pkg;

   localparam int NUM_SLOTS_DEF  = 1024;
   localparam int CYCLE_BITS_DEF = 32;

   localparam logic [15:0] REUSE_DELAY_RESET = 16'd500;

   localparam logic [1:0] KIND_ALLOC    = 2'd0;
   localparam logic [1:0] KIND_ACTIVATE = 2'd1;
   localparam logic [1:0] KIND_RELEASE  = 2'd2;

   localparam logic [1:0] STATUS_OK           = 2'd0;
   localparam logic [1:0] STATUS_OUT_OF_SLOTS = 2'd1;
   localparam logic [1:0] STATUS_BAD_SLOT     = 2'd2;
   localparam logic [1:0] STATUS_WRONG_STATE  = 2'd3;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOOKUP,
      ST_UPDATE
   } state_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [9:0]  slot_index;
      logic [31:0] now_cycle;
   } req_type;

   typedef struct packed {
      logic [9:0]  granted_slot;
      logic        reused;
      logic [1:0]  status;
      logic [10:0] active_count;
      logic        last_valid;
      logic [9:0]  last_created;
   } rsp_type;

endpackage

>>> rtl/slot_allocator_delayed_reuse_core.sv
// Top level: slot allocator with delayed reuse and a dense active list.
//
//  channel  | ports                     | handshake
//  ---------+---------------------------+-------------------------------------
//  request  | start, busy, req_data     | taken at an edge with start & !busy
//  result   | rsp_valid, rsp_data       | one-cycle strobe, no back-pressure
//  config   | csr_we, csr_wdata         | reuse delay written when csr_we high
//
// Allocate ends in ST_LOOKUP; activate and release go on to ST_UPDATE unless the slot
// is out of range or released. The memories are read at the accept edge, the active
// list is read at the looked-up position as ST_LOOKUP ends; writes and the result register
// land as the last state ends. busy is low again in the cycle the result shows.
// Reset is synchronous and clears all control state; the memories hold no
// reset value and need no clearing pass. The receiver cannot stall results.
`timescale 1ns / 1ps

module slot_allocator_delayed_reuse_core #(
   parameter int NUM_SLOTS  = sadr_pkg::NUM_SLOTS_DEF,
   parameter int CYCLE_BITS = sadr_pkg::CYCLE_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  sadr_pkg::req_type req_data,
   output logic              rsp_valid,
   output sadr_pkg::rsp_type rsp_data,
   input  logic              csr_we,
   input  logic [15:0]       csr_wdata
);
   import sadr_pkg::*;

   localparam int SW     = $clog2(NUM_SLOTS);
   localparam int CW     = $clog2(NUM_SLOTS + 1);
   localparam int SLOT_W = 10;
   localparam int EW     = (CW > SLOT_W) ? CW : SLOT_W;

   // control and request registers
   state_type             state_ff, state_in;
   logic [1:0]            kind_ff;
   logic [SLOT_W-1:0]     slot_ff;
   logic [CYCLE_BITS-1:0] now_ff;
   logic [CW-1:0]         created_ff, created_in;
   logic [SW-1:0]         head_ff, head_in;
   logic [SW-1:0]         tail_ff, tail_in;
   logic [CW-1:0]         fcount_ff, fcount_in;
   logic [CW-1:0]         total_ff, total_in;
   logic [SW-1:0]         last_ff, last_in;
   logic                  last_valid_ff, last_valid_in;
   logic [15:0]           delay_ff;
   logic                  rsp_valid_ff;
   rsp_type               rsp_data_ff, rsp_in;

   // memories and their read registers
   logic [SW-1:0]         fq_slot_mem [NUM_SLOTS];
   logic [CYCLE_BITS-1:0] fq_due_mem  [NUM_SLOTS];
   logic                  rel_mem     [NUM_SLOTS];
   logic [CW-1:0]         pos_mem     [NUM_SLOTS];
   logic [SW-1:0]         al_mem      [NUM_SLOTS];

   logic [SW-1:0]         fq_slot_rd_ff;
   logic [CYCLE_BITS-1:0] fq_due_rd_ff;
   logic                  rel_rd_ff;
   logic [CW-1:0]         pos_rd_ff;
   logic [SW-1:0]         al_pos_rd_ff;
   logic [SW-1:0]         al_last_rd_ff;

   // write controls
   logic                  fq_we;
   logic [CYCLE_BITS-1:0] due_w;
   logic                  rel_we, rel_wdata;
   logic [SW-1:0]         rel_waddr;
   logic                  pos_we;
   logic [SW-1:0]         pos_waddr;
   logic [CW-1:0]         pos_wdata;
   logic                  al_we;
   logic [SW-1:0]         al_waddr, al_wdata;

   logic                  accept, done, reused, is_act, bad;
   logic [SW-1:0]         slot_w;
   logic [SLOT_W-1:0]     granted;
   logic [1:0]            status;

   assign busy      = (state_ff != ST_IDLE);
   assign accept    = start && !busy;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign slot_w = SW'(slot_ff);
   assign bad    = (EW'(slot_ff) >= EW'(created_ff));
   assign due_w  = now_ff + CYCLE_BITS'(delay_ff);
   // a stale position is harmless: only live list entries are compared
   assign is_act = (pos_rd_ff < total_ff) && (al_pos_rd_ff == slot_w);

   // free queue: write at tail, read head at accept
   always_ff @(posedge clock) begin
      if (fq_we) begin
         fq_slot_mem[tail_ff] <= slot_w;
         fq_due_mem[tail_ff]  <= due_w;
      end
      if (accept) begin
         fq_slot_rd_ff <= fq_slot_mem[head_ff];
         fq_due_rd_ff  <= fq_due_mem[head_ff];
      end
   end

   // released flags and active positions, read by request slot at accept
   always_ff @(posedge clock) begin
      if (rel_we) begin
         rel_mem[rel_waddr] <= rel_wdata;
      end
      if (pos_we) begin
         pos_mem[pos_waddr] <= pos_wdata;
      end
      if (accept) begin
         rel_rd_ff <= rel_mem[SW'(req_data.slot_index)];
         pos_rd_ff <= pos_mem[SW'(req_data.slot_index)];
      end
   end

   // active list: read at looked-up position and at the tail entry
   always_ff @(posedge clock) begin
      if (al_we) begin
         al_mem[al_waddr] <= al_wdata;
      end
      if (state_ff == ST_LOOKUP) begin
         al_pos_rd_ff  <= al_mem[SW'(pos_rd_ff)];
         al_last_rd_ff <= al_mem[SW'(total_ff - CW'(1))];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         created_ff    <= '0;
         head_ff       <= '0;
         tail_ff       <= '0;
         fcount_ff     <= '0;
         total_ff      <= '0;
         last_ff       <= '0;
         last_valid_ff <= 1'b0;
         delay_ff      <= REUSE_DELAY_RESET;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         created_ff    <= created_in;
         head_ff       <= head_in;
         tail_ff       <= tail_in;
         fcount_ff     <= fcount_in;
         total_ff      <= total_in;
         last_ff       <= last_in;
         last_valid_ff <= last_valid_in;
         rsp_valid_ff  <= done;
         if (csr_we) begin
            delay_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         kind_ff <= req_data.kind;
         slot_ff <= req_data.slot_index;
         now_ff  <= CYCLE_BITS'(req_data.now_cycle);
      end
      if (done) begin
         rsp_data_ff <= rsp_in;
      end
   end

   always_comb begin
      state_in      = state_ff;
      created_in    = created_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      fcount_in     = fcount_ff;
      total_in      = total_ff;
      last_in       = last_ff;
      last_valid_in = last_valid_ff;
      fq_we         = 1'b0;
      rel_we        = 1'b0;
      rel_waddr     = slot_w;
      rel_wdata     = 1'b0;
      pos_we        = 1'b0;
      pos_waddr     = slot_w;
      pos_wdata     = total_ff;
      al_we         = 1'b0;
      al_waddr      = SW'(total_ff);
      al_wdata      = slot_w;
      done          = 1'b0;
      granted       = slot_ff;
      reused        = 1'b0;
      status        = STATUS_OK;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            case (kind_ff)
               KIND_ALLOC: begin
                  done = 1'b1;
                  if (fcount_ff != '0 && fq_due_rd_ff < now_ff) begin
                     // pop the oldest released slot
                     granted   = SLOT_W'(fq_slot_rd_ff);
                     reused    = 1'b1;
                     fcount_in = fcount_ff - CW'(1);
                     if (head_ff == SW'(NUM_SLOTS - 1)) begin
                        head_in = '0;
                     end else begin
                        head_in = head_ff + SW'(1);
                     end
                     rel_we    = 1'b1;
                     rel_waddr = fq_slot_rd_ff;
                  end else if (created_ff < CW'(NUM_SLOTS)) begin
                     granted    = SLOT_W'(created_ff);
                     created_in = created_ff + CW'(1);
                     rel_we     = 1'b1;
                     rel_waddr  = SW'(created_ff);
                  end else begin
                     granted = '0;
                     status  = STATUS_OUT_OF_SLOTS;
                  end
               end
               KIND_ACTIVATE, KIND_RELEASE: begin
                  if (bad) begin
                     status = STATUS_BAD_SLOT;
                     done   = 1'b1;
                  end else if (rel_rd_ff) begin
                     status = STATUS_WRONG_STATE;
                     done   = 1'b1;
                  end
               end
               default: begin
                  status = STATUS_WRONG_STATE;
                  done   = 1'b1;
               end
            endcase
            if (done) begin
               state_in = ST_IDLE;
            end else begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            done     = 1'b1;
            state_in = ST_IDLE;
            if (kind_ff == KIND_ACTIVATE) begin
               if (is_act) begin
                  status = STATUS_WRONG_STATE;
               end else begin
                  al_we         = 1'b1;
                  pos_we        = 1'b1;
                  total_in      = total_ff + CW'(1);
                  last_in       = slot_w;
                  last_valid_in = 1'b1;
               end
            end else begin
               if (last_valid_ff && last_ff == slot_w) begin
                  last_valid_in = 1'b0;
                  last_in       = '0;
               end
               if (is_act) begin
                  // move the tail entry into the hole
                  al_we     = 1'b1;
                  al_waddr  = SW'(pos_rd_ff);
                  al_wdata  = al_last_rd_ff;
                  pos_we    = 1'b1;
                  pos_waddr = al_last_rd_ff;
                  pos_wdata = pos_rd_ff;
                  total_in  = total_ff - CW'(1);
               end
               rel_we    = 1'b1;
               rel_wdata = 1'b1;
               fq_we     = 1'b1;
               fcount_in = fcount_ff + CW'(1);
               if (tail_ff == SW'(NUM_SLOTS - 1)) begin
                  tail_in = '0;
               end else begin
                  tail_in = tail_ff + SW'(1);
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      rsp_in.granted_slot = granted;
      rsp_in.reused       = reused;
      rsp_in.status       = status;
      rsp_in.active_count = 11'(total_in);
      rsp_in.last_valid   = last_valid_in;
      rsp_in.last_created = SLOT_W'(last_in);
   end

endmodule

>>> rtl/sadr_checker.sv
// Port-level checker for the slot allocator, bound to the top level.
`timescale 1ns / 1ps
`include "slot_allocator_delayed_reuse_core_defines.svh"

module sadr_checker (
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input logic              rsp_valid,
   input sadr_pkg::rsp_type rsp_data
);
   import sadr_pkg::*;

   logic accept;
   logic oos_rsp;
   logic oos_clean;
   assign accept    = start && !busy;
   assign oos_rsp   = rsp_valid && (rsp_data.status == STATUS_OUT_OF_SLOTS);
   assign oos_clean = (rsp_data.granted_slot == '0) && !rsp_data.reused;

   `SADR_ASSERT_NEXT(a_accept_busy, clock, reset, accept, busy, "busy low after request")
   `SADR_ASSERT_NEXT(a_no_early_rsp, clock, reset, accept, !rsp_valid, "result too early")
   `SADR_ASSERT_NOW(a_rsp_idle, clock, reset, rsp_valid, !busy, "result while busy")
   `SADR_ASSERT_NEXT(a_rsp_single, clock, reset, rsp_valid, !rsp_valid, "result repeated")
   `SADR_ASSERT_NOW(a_oos_clean, clock, reset, oos_rsp, oos_clean, "out of slots with a grant")

endmodule

bind slot_allocator_delayed_reuse_core sadr_checker u_sadr_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp_data  (rsp_data)
);
